FILE: src/cpu6502_pkg.sv
// Package for the 6502 subset core: payload structs, micro-step codes, opcodes.
// No dependencies.
`default_nettype none
package cpu6502_pkg;

	typedef struct packed {
		logic [7:0] read_data;
		logic       nmi_request;
	} in_item_t;

	typedef struct packed {
		logic [15:0] bus_address;
		logic        bus_write;
		logic [7:0]  write_data;
		logic        instruction_done;
		logic [15:0] program_counter;
		logic [7:0]  accumulator;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  flags;
		logic [7:0]  stack_pointer;
	} out_item_t;

	typedef enum logic [3:0] {
		STEP_RESET = 4'd0,
		STEP_VLO   = 4'd1,
		STEP_VHI   = 4'd2,
		STEP_OPC   = 4'd3,
		STEP_OP1   = 4'd4,
		STEP_OP2   = 4'd5,
		STEP_PTRL  = 4'd6,
		STEP_PTRH  = 4'd7,
		STEP_DATA  = 4'd8,
		STEP_WRITE = 4'd9,
		STEP_PUSHL = 4'd10,
		STEP_PUSHP = 4'd11,
		STEP_VEC   = 4'd12,
		STEP_POPL  = 4'd13,
		STEP_POPH  = 4'd14
	} step_t;

	// Architectural state carried between bus cycles
	typedef struct packed {
		logic [15:0] pc;
		logic [7:0]  a;
		logic [7:0]  x;
		logic [7:0]  y;
		logic [7:0]  p;
		logic [7:0]  sp;
		logic [7:0]  opc;
		logic [7:0]  opl;
		logic [7:0]  oph;
		logic [15:0] ea;
		step_t       step;
		logic        nmi;
	} core_state_t;

	localparam logic [7:0] OP_BRK = 8'h00, OP_ORA_IX = 8'h01, OP_ORA_ZP = 8'h05,
		OP_BPL = 8'h10, OP_JSR = 8'h20, OP_BMI = 8'h30, OP_RTS = 8'h60,
		OP_SEI = 8'h78, OP_STA_IX = 8'h81, OP_STA_ZP = 8'h85, OP_STA_AB = 8'h8D,
		OP_STA_IY = 8'h91, OP_STA_ZX = 8'h95, OP_STA_AY = 8'h99, OP_TXS = 8'h9A,
		OP_STA_AX = 8'h9D, OP_LDY = 8'hA0, OP_LDX = 8'hA2, OP_LDA_IM = 8'hA9,
		OP_LDA_AB = 8'hAD, OP_INY = 8'hC8, OP_BNE = 8'hD0, OP_CLD = 8'hD8;

	localparam logic [15:0] VEC_RESET = 16'hFFFC;
	localparam logic [15:0] VEC_NMI   = 16'hFFFA;
	localparam logic [15:0] VEC_BRK   = 16'hFFFE;
	localparam logic [7:0]  P_RESET   = 8'h36;
	localparam logic [7:0]  SP_RESET  = 8'hFF;
	localparam logic [7:0]  STACK_PAGE = 8'h01;
	localparam logic [7:0]  FLAG_I = 8'h04, FLAG_N = 8'h80, FLAG_Z = 8'h02;

endpackage
`default_nettype wire

FILE: src/cpu6502_step.sv
// Combinational next-state logic for one bus cycle of the core.
// Depends on cpu6502_pkg.
`default_nettype none
module cpu6502_step (
	input  wire cpu6502_pkg::core_state_t cur,
	input  wire cpu6502_pkg::in_item_t    din,
	output cpu6502_pkg::core_state_t      nxt,
	output cpu6502_pkg::out_item_t        bus
);
	import cpu6502_pkg::*;

	always_comb begin
		logic [7:0]  rd;
		logic [7:0]  v;
		logic        take;
		logic        bnd;
		rd = din.read_data;
		nxt = cur;
		take = 1'b0;
		bnd = 1'b0;
		v = 8'h00;
		if (din.nmi_request) nxt.nmi = 1'b1;
		bus = '0;

		unique case (cur.step) inside
			STEP_RESET: begin
				nxt.ea = VEC_RESET;
				bus.bus_address = VEC_RESET;
				nxt.step = STEP_VLO;
			end
			STEP_VLO: begin
				nxt.opl = rd;
				bus.bus_address = cur.ea + 16'd1;
				nxt.step = STEP_VHI;
			end
			STEP_VHI: begin
				nxt.oph = rd;
				nxt.pc = {rd, cur.opl};
				bnd = 1'b1;
			end
			STEP_OPC: begin
				nxt.opc = rd;
				nxt.pc = cur.pc + 16'd1;
				unique case (rd) inside
					OP_BRK: begin
						nxt.pc = cur.pc + 16'd2;
						nxt.ea = VEC_BRK;
						v = nxt.pc[15:8];
						bus.bus_address = {STACK_PAGE, cur.sp};
						bus.bus_write = 1'b1;
						bus.write_data = v;
						nxt.sp = cur.sp - 8'd1;
						nxt.step = STEP_PUSHL;
					end
					OP_RTS: begin
						nxt.sp = cur.sp + 8'd1;
						bus.bus_address = {STACK_PAGE, nxt.sp};
						nxt.step = STEP_POPL;
					end
					OP_SEI: begin nxt.p = cur.p | FLAG_I; bnd = 1'b1; end
					OP_TXS: begin nxt.sp = cur.x; bnd = 1'b1; end
					OP_INY: begin
						nxt.y = cur.y + 8'd1;
						nxt.p = (cur.p & 8'h7D) | (nxt.y & FLAG_N) |
							((nxt.y == 8'd0) ? FLAG_Z : 8'h00);
						bnd = 1'b1;
					end
					OP_CLD: begin nxt.p = cur.p & 8'hF7; bnd = 1'b1; end
					OP_ORA_IX, OP_ORA_ZP, OP_BPL, OP_JSR, OP_BMI, OP_STA_IX,
					OP_STA_ZP, OP_STA_AB, OP_STA_IY, OP_STA_ZX, OP_STA_AY,
					OP_STA_AX, OP_LDY, OP_LDX, OP_LDA_IM, OP_LDA_AB, OP_BNE: begin
						bus.bus_address = nxt.pc;
						nxt.step = STEP_OP1;
					end
					default: bnd = 1'b1;
				endcase
			end
			STEP_OP1: begin
				nxt.opl = rd;
				nxt.pc = cur.pc + 16'd1;
				unique case (cur.opc) inside
					OP_LDY, OP_LDX, OP_LDA_IM: begin
						if (cur.opc == OP_LDY) nxt.y = rd;
						else if (cur.opc == OP_LDX) nxt.x = rd;
						else nxt.a = rd;
						nxt.p = (cur.p & 8'h7D) | (rd & FLAG_N) |
							((rd == 8'd0) ? FLAG_Z : 8'h00);
						bnd = 1'b1;
					end
					OP_BPL, OP_BMI, OP_BNE: begin
						if (cur.opc == OP_BPL) take = (cur.p & FLAG_N) == 8'd0;
						else if (cur.opc == OP_BMI) take = (cur.p & FLAG_N) != 8'd0;
						else take = (cur.p & FLAG_Z) == 8'd0;
						if (take) nxt.pc = cur.pc + 16'd1 + {{8{rd[7]}}, rd};
						bnd = 1'b1;
					end
					OP_ORA_ZP: begin
						nxt.ea = {8'h00, rd};
						bus.bus_address = nxt.ea;
						nxt.step = STEP_DATA;
					end
					OP_STA_ZP, OP_STA_ZX: begin
						nxt.ea = {8'h00, (cur.opc == OP_STA_ZX) ? rd + cur.x : rd};
						bus.bus_address = nxt.ea;
						bus.bus_write = 1'b1;
						bus.write_data = cur.a;
						nxt.step = STEP_WRITE;
					end
					OP_ORA_IX, OP_STA_IX, OP_STA_IY: begin
						nxt.ea = {8'h00, (cur.opc == OP_STA_IY) ? rd : rd + cur.x};
						bus.bus_address = nxt.ea;
						nxt.step = STEP_PTRL;
					end
					default: begin
						bus.bus_address = nxt.pc;
						nxt.step = STEP_OP2;
					end
				endcase
			end
			STEP_OP2, STEP_PTRH: begin
				nxt.oph = rd;
				nxt.ea = {rd, cur.opl};
				if (cur.step == STEP_OP2 && cur.opc == OP_JSR) begin
					bus.bus_address = {STACK_PAGE, cur.sp};
					bus.bus_write = 1'b1;
					bus.write_data = cur.pc[15:8];
					nxt.sp = cur.sp - 8'd1;
					nxt.step = STEP_PUSHL;
				end else begin
					if (cur.step == STEP_OP2) begin
						nxt.pc = cur.pc + 16'd1;
						if (cur.opc == OP_STA_AY) nxt.ea = {rd, cur.opl} + {8'h00, cur.y};
						else if (cur.opc == OP_STA_AX)
							nxt.ea = {rd, cur.opl} + {8'h00, cur.x};
					end else if (cur.opc == OP_STA_IY) begin
						nxt.ea = {rd, cur.opl} + {8'h00, cur.y};
					end
					bus.bus_address = nxt.ea;
					if (cur.opc == OP_ORA_IX || cur.opc == OP_ORA_ZP ||
						cur.opc == OP_LDA_AB) begin
						nxt.step = STEP_DATA;
					end else begin
						bus.bus_write = 1'b1;
						bus.write_data = cur.a;
						nxt.step = STEP_WRITE;
					end
				end
			end
			STEP_PTRL: begin
				nxt.opl = rd;
				bus.bus_address = {8'h00, cur.ea[7:0] + 8'd1};
				nxt.step = STEP_PTRH;
			end
			STEP_DATA: begin
				nxt.a = (cur.opc == OP_LDA_AB) ? rd : (cur.a | rd);
				nxt.p = (cur.p & 8'h7D) | (nxt.a & FLAG_N) |
					((nxt.a == 8'd0) ? FLAG_Z : 8'h00);
				bnd = 1'b1;
			end
			STEP_PUSHL: begin
				bus.bus_address = {STACK_PAGE, cur.sp};
				bus.bus_write = 1'b1;
				bus.write_data = cur.pc[7:0];
				nxt.sp = cur.sp - 8'd1;
				nxt.step = STEP_PUSHP;
			end
			STEP_PUSHP: begin
				if (cur.opc == OP_JSR) begin
					nxt.pc = cur.ea;
					bnd = 1'b1;
				end else begin
					bus.bus_address = {STACK_PAGE, cur.sp};
					bus.bus_write = 1'b1;
					bus.write_data = (cur.ea == VEC_BRK) ? (cur.p | 8'h30) :
						((cur.p | 8'h20) & 8'hEF);
					nxt.sp = cur.sp - 8'd1;
					nxt.p = cur.p | FLAG_I;
					nxt.step = STEP_VEC;
				end
			end
			STEP_VEC: begin
				bus.bus_address = cur.ea;
				nxt.step = STEP_VLO;
			end
			STEP_POPL: begin
				nxt.opl = rd;
				nxt.sp = cur.sp + 8'd1;
				bus.bus_address = {STACK_PAGE, nxt.sp};
				nxt.step = STEP_POPH;
			end
			STEP_POPH: begin
				nxt.oph = rd;
				nxt.pc = {rd, cur.opl} + 16'd1;
				bnd = 1'b1;
			end
			default: bnd = 1'b1;
		endcase

		// Instruction boundary: NMI entry or opcode fetch
		if (bnd) begin
			if (nxt.nmi) begin
				nxt.nmi = 1'b0;
				nxt.opc = OP_BRK;
				nxt.ea = VEC_NMI;
				bus.bus_address = {STACK_PAGE, nxt.sp};
				bus.bus_write = 1'b1;
				bus.write_data = nxt.pc[15:8];
				bus.instruction_done = 1'b0;
				nxt.sp = nxt.sp - 8'd1;
				nxt.step = STEP_PUSHL;
			end else begin
				bus.bus_address = nxt.pc;
				bus.bus_write = 1'b0;
				bus.write_data = 8'h00;
				bus.instruction_done = 1'b1;
				nxt.step = STEP_OPC;
			end
		end

		bus.program_counter = nxt.pc;
		bus.accumulator = nxt.a;
		bus.index_x = nxt.x;
		bus.index_y = nxt.y;
		bus.flags = nxt.p;
		bus.stack_pointer = nxt.sp;
	end
endmodule
`default_nettype wire

FILE: src/cpu_core_6502_subset.sv
// Top level of the 6502 subset core: state register, result register, handshake.
// Depends on cpu6502_pkg and cpu6502_step.
//
//  channel | direction | payload     | handshake
//  in      | input     | in_item_t   | in_valid / in_stall
//  out     | output    | out_item_t  | out_valid / out_stall
//
// One transaction per cycle while in_stall is low: each accepted bus cycle updates
// the core state in the same edge and its result is held in a single output register.
// The result is registered; the micro-step sequencer sets one bus access per item.
// Reset sets the state register to its power-on values and clears out_valid; the vector fetch follows.
// Input is stalled only while a result waits and the output is stalled.
`default_nettype none
module cpu_core_6502_subset (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire cpu6502_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output cpu6502_pkg::out_item_t out_data
);
	import cpu6502_pkg::*;

	core_state_t st_q, st_next;
	out_item_t   res;
	logic        acc;

	cpu6502_step u_step (.cur(st_q), .din(in_data), .nxt(st_next), .bus(res));

	assign in_stall = out_valid && out_stall;
	assign acc = in_valid && !in_stall;

	// Core state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{pc: 16'd0, a: 8'd0, x: 8'd0, y: 8'd0, p: P_RESET, sp: SP_RESET,
				opc: 8'd0, opl: 8'd0, oph: 8'd0, ea: 16'd0, step: STEP_RESET,
				nmi: 1'b0};
		end else if (acc) begin
			st_q <= st_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (acc) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) out_data <= res;
	end

	// Checks
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.bus_write |-> out_data.write_data == 8'h00)
		else $error("write data on a read");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.instruction_done |->
		!out_data.bus_write && out_data.bus_address == out_data.program_counter)
		else $error("opcode fetch not at pc");
endmodule
`default_nettype wire
